/* rtl/tscan_pkg.sv */
package tscan_pkg;

    // Widths of the position and line counters.
    localparam int POS_BITS  = 16;
    localparam int LINE_BITS = 16;

    // Widths of the result fields on the ports.
    localparam int FIELD_BITS = 16;
    localparam int KIND_BITS  = 4;

    localparam logic [POS_BITS-1:0]  POS_MAX  = {POS_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

    // Depth of the result queue and the widths of its pointer and fill count.
    localparam int QDEPTH = 4;
    localparam int QPTR_BITS = $clog2(QDEPTH);
    localparam int QCNT_BITS = $clog2(QDEPTH + 1);

    typedef enum logic [KIND_BITS-1:0] {
        KIND_END     = 4'd0,
        KIND_INT     = 4'd1,
        KIND_SEMI    = 4'd2,
        KIND_COLONS  = 4'd3,
        KIND_LPAREN  = 4'd4,
        KIND_RPAREN  = 4'd5,
        KIND_LBRACE  = 4'd6,
        KIND_RBRACE  = 4'd7,
        KIND_SYM     = 4'd8
    } kind_t;

    // One-hot scanner modes.
    typedef enum logic [4:0] {
        MODE_IDLE  = 5'b00001,
        MODE_INT   = 5'b00010,
        MODE_SYM   = 5'b00100,
        MODE_COLON = 5'b01000,
        MODE_STOP  = 5'b10000
    } mode_t;

    // One token as it is queued for the output.
    typedef struct packed {
        kind_t                  kind;
        logic [FIELD_BITS-1:0]  start;
        logic [FIELD_BITS-1:0]  len;
        logic [FIELD_BITS-1:0]  line;
        logic                   stop;
        logic                   last;
    } result_t;

    // Clamps a counter value to the width of a result field.
    function automatic logic [FIELD_BITS-1:0] clamp_field(input logic [31:0] v);
        logic [FIELD_BITS-1:0] r;
        if (v > 32'(FIELD_BITS'('1)))
            r = '1;
        else
            r = v[FIELD_BITS-1:0];
        return r;
    endfunction

endpackage

/* rtl/token_scanner_top.sv */
// Token scanner.
//
// Source text enters on the s_axis channel, one character per item, with
// tlast marking the end of the text (a NUL character has the same effect).
// Tokens leave on the m_axis channel: start position, length and starting
// line in tdata, kind and the stopped flag in tuser, and tlast set on the
// last token caused by one character.
//
// Each accepted character is classified and the scanner mode, position and
// line counters are updated in the same cycle; the tokens it causes (none,
// one or two) are written to a four-entry result queue, from which m_axis
// presents them in order. A new character is accepted every cycle while
// the queue has room for two tokens, so the input sustains one item per
// cycle whenever each character yields at most one token and the output
// takes one token per cycle; a character that closes a run and also yields
// a token of its own produces two tokens, which the output takes in turn.
//
// Reset empties the queue and returns the scanner to its idle mode at
// position zero on line one. When the receiver stalls, the queue fills and
// s_axis_tready falls; no token is lost or repeated.
module token_scanner_top
    import tscan_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,   // end_of_text

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [15:0] start_pos, [31:16] token_length,
                                        // [47:32] line_number
    output logic [4:0]  m_axis_tuser,   // [3:0] token_kind, [4] stopped_early
    output logic        m_axis_tlast    // last_in_run
);

    // Scanner state.
    mode_t                 mode_reg, mode_next;
    logic [POS_BITS-1:0]   pos_reg, pos_next;
    logic [POS_BITS-1:0]   start_reg, start_next;
    logic [LINE_BITS-1:0]  line_reg, line_next;
    logic [LINE_BITS-1:0]  tline_reg, tline_next;

    // Result queue.
    result_t               queue_reg [QDEPTH];
    logic [QPTR_BITS-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_BITS-1:0]  count_reg;

    logic                  in_fire, out_fire;
    logic [1:0]            n_res;
    result_t               res0, res1;

    logic [7:0]            ch;
    logic                  fin;
    logic [POS_BITS-1:0]   pos_inc;
    logic [LINE_BITS-1:0]  line_inc;

    // Handling of a character in idle mode, used both from idle and after a
    // run token has been closed by the same character.
    logic                  idle_emit;
    result_t               idle_res;
    mode_t                 idle_mode;
    logic [POS_BITS-1:0]   idle_pos, idle_start;
    logic [LINE_BITS-1:0]  idle_line, idle_tline;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic is_sym(input logic [7:0] c);
        return is_digit(c) || ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"))
            || (c inside {"~", "!", "?", ".", "/", ",", "<", ">", "_", "+", "=", "-",
                          ":", "$", "%", "^", "&", "\\", "[", "]"});
    endfunction

    function automatic result_t make_res(input kind_t k, input logic [POS_BITS-1:0] s,
                                         input logic [POS_BITS-1:0] l,
                                         input logic [LINE_BITS-1:0] ln,
                                         input logic stp);
        result_t r;
        r.kind  = k;
        r.start = clamp_field(32'(s));
        r.len   = clamp_field(32'(l));
        r.line  = clamp_field(32'(ln));
        r.stop  = stp;
        r.last  = 1'b1;
        return r;
    endfunction

    assign ch      = s_axis_tdata;
    assign fin     = s_axis_tlast || (ch == 8'd0);
    assign pos_inc = (pos_reg < POS_MAX) ? pos_reg + 1'b1 : pos_reg;
    assign line_inc = (line_reg < LINE_MAX) ? line_reg + 1'b1 : line_reg;

    always_comb
    begin
        idle_emit  = 1'b0;
        idle_res   = make_res(KIND_END, pos_reg, '0, line_reg, 1'b0);
        idle_mode  = MODE_IDLE;
        idle_pos   = pos_inc;
        idle_start = start_reg;
        idle_line  = line_reg;
        idle_tline = tline_reg;
        if (is_space(ch))
        begin
            if (ch == 8'd10)
                idle_line = line_inc;
        end
        else if (is_digit(ch) || ch == ":")
        begin
            idle_mode  = is_digit(ch) ? MODE_INT : MODE_COLON;
            idle_start = pos_reg;
            idle_tline = line_reg;
        end
        else if (ch == ";" || ch == "(" || ch == ")" || ch == "{" || ch == "}")
        begin
            idle_emit = 1'b1;
            case (ch)
                ";":     idle_res = make_res(KIND_SEMI,   pos_reg, POS_BITS'(1), line_reg, 1'b0);
                "(":     idle_res = make_res(KIND_LPAREN, pos_reg, POS_BITS'(1), line_reg, 1'b0);
                ")":     idle_res = make_res(KIND_RPAREN, pos_reg, POS_BITS'(1), line_reg, 1'b0);
                "{":     idle_res = make_res(KIND_LBRACE, pos_reg, POS_BITS'(1), line_reg, 1'b0);
                default: idle_res = make_res(KIND_RBRACE, pos_reg, POS_BITS'(1), line_reg, 1'b0);
            endcase
        end
        else if (is_sym(ch))
        begin
            idle_mode  = MODE_SYM;
            idle_start = pos_reg;
            idle_tline = line_reg;
        end
        else
        begin
            // Unclassified character: stop the scan with an end token.
            idle_emit = 1'b1;
            idle_res  = make_res(KIND_END, pos_reg, '0, line_reg, 1'b1);
            idle_mode = MODE_STOP;
            idle_pos  = pos_reg;
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        line_next  = line_reg;
        tline_next = tline_reg;
        n_res      = 2'd0;
        res0       = idle_res;
        res1       = idle_res;
        if (fin)
        begin
            unique case (mode_reg)
                MODE_INT, MODE_SYM:
                begin
                    res0 = make_res((mode_reg == MODE_INT) ? KIND_INT : KIND_SYM, start_reg,
                                    pos_reg - start_reg, tline_reg, 1'b0);
                    res0.last = 1'b0;
                    res1  = make_res(KIND_END, pos_reg, '0, line_reg, 1'b0);
                    n_res = 2'd2;
                end
                MODE_COLON:
                begin
                    res0  = make_res(KIND_END, start_reg, '0, tline_reg, 1'b1);
                    n_res = 2'd1;
                end
                MODE_IDLE:
                begin
                    res0  = make_res(KIND_END, pos_reg, '0, line_reg, 1'b0);
                    n_res = 2'd1;
                end
                MODE_STOP: n_res = 2'd0;
                default:   n_res = 2'd0;
            endcase
            mode_next  = MODE_IDLE;
            pos_next   = '0;
            start_next = '0;
            line_next  = LINE_BITS'(1);
            tline_next = LINE_BITS'(1);
        end
        else
        begin
            unique case (mode_reg)
                MODE_IDLE:
                begin
                    res0       = idle_res;
                    n_res      = {1'b0, idle_emit};
                    mode_next  = idle_mode;
                    pos_next   = idle_pos;
                    start_next = idle_start;
                    line_next  = idle_line;
                    tline_next = idle_tline;
                end
                MODE_INT, MODE_SYM:
                begin
                    if ((mode_reg == MODE_INT) ? is_digit(ch) : is_sym(ch))
                        pos_next = pos_inc;
                    else
                    begin
                        // The run ends here and this character is scanned afresh.
                        res0 = make_res((mode_reg == MODE_INT) ? KIND_INT : KIND_SYM,
                                        start_reg, pos_reg - start_reg, tline_reg, 1'b0);
                        res0.last  = !idle_emit;
                        res1       = idle_res;
                        n_res      = idle_emit ? 2'd2 : 2'd1;
                        mode_next  = idle_mode;
                        pos_next   = idle_pos;
                        start_next = idle_start;
                        line_next  = idle_line;
                        tline_next = idle_tline;
                    end
                end
                MODE_COLON:
                begin
                    n_res = 2'd1;
                    if (ch == ":")
                    begin
                        res0      = make_res(KIND_COLONS, start_reg, pos_inc - start_reg,
                                             tline_reg, 1'b0);
                        pos_next  = pos_inc;
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        // A lone colon stops the scan.
                        res0      = make_res(KIND_END, start_reg, '0, tline_reg, 1'b1);
                        mode_next = MODE_STOP;
                    end
                end
                MODE_STOP: n_res = 2'd0;
                default:   n_res = 2'd0;
            endcase
        end
    end

    // The queue takes a character only while two entries are free.
    assign s_axis_tready = (count_reg <= QCNT_BITS'(QDEPTH - 2));
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (count_reg != '0);
    assign out_fire      = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            pos_reg    <= '0;
            start_reg  <= '0;
            line_reg   <= LINE_BITS'(1);
            tline_reg  <= LINE_BITS'(1);
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                mode_reg   <= mode_next;
                pos_reg    <= pos_next;
                start_reg  <= start_next;
                line_reg   <= line_next;
                tline_reg  <= tline_next;
                wr_ptr_reg <= wr_ptr_reg + QPTR_BITS'(n_res);
            end
            if (out_fire)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + (in_fire ? QCNT_BITS'(n_res) : '0)
                                   - (out_fire ? QCNT_BITS'(1) : '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && n_res != 2'd0)
            queue_reg[wr_ptr_reg] <= res0;
        if (in_fire && n_res == 2'd2)
            queue_reg[wr_ptr_reg + 1'b1] <= res1;
    end

    assign m_axis_tdata = {queue_reg[rd_ptr_reg].line, queue_reg[rd_ptr_reg].len,
                           queue_reg[rd_ptr_reg].start};
    assign m_axis_tuser = {queue_reg[rd_ptr_reg].stop, queue_reg[rd_ptr_reg].kind};
    assign m_axis_tlast = queue_reg[rd_ptr_reg].last;

endmodule
